[sv/ubx_frame_sniffer_rf_sat_stats_top_assert.svh]
// Assertion macros used by the checker module of the UBX sniffer.
`ifndef UBX_FRAME_SNIFFER_RF_SAT_STATS_TOP_ASSERT_SVH
`define UBX_FRAME_SNIFFER_RF_SAT_STATS_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define UBXS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define UBXS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ubxs_pkg.sv]
`default_nettype none

package ubxs_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_FIRST  = 3'd0,
        CFG_SYNC_SECOND = 3'd1,
        CFG_NAV_CLASS   = 3'd2,
        CFG_SAT_ID      = 3'd3,
        CFG_MON_CLASS   = 3'd4,
        CFG_RF_ID       = 3'd5
    } t_cfg_idx;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h62;
    localparam logic [7:0] NAV_CLASS_RST   = 8'h01;
    localparam logic [7:0] SAT_ID_RST      = 8'h35;
    localparam logic [7:0] MON_CLASS_RST   = 8'h0A;
    localparam logic [7:0] RF_ID_RST       = 8'h38;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] nav_class;
        logic [7:0] sat_id;
        logic [7:0] mon_class;
        logic [7:0] rf_id;
    } t_cfg;

    // Frame kind reported with each result
    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_RF    = 2'd1,
        KIND_SAT   = 2'd2
    } t_kind;

    // Operations handed from the framer to the capture side
    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_PAY    = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    // Payload offsets below 2**LEAD_IDX_W (32) land in the lead window
    localparam int unsigned LEAD_IDX_W = 5;

    typedef struct packed {
        t_op                   op;
        logic [7:0]            data;
        logic [LEAD_IDX_W-1:0] idx;
        logic                  in_lead;
        logic                  sat_cnt;
        logic                  cno;
        logic [7:0]            cls;
        logic [7:0]            id;
        t_kind                 kind;
    } t_qent;

    // RF block-0 byte offsets within the payload (block 0 starts at 4)
    localparam logic [LEAD_IDX_W-1:0] OFF_RF_FLAGS   = 5'd5;
    localparam logic [LEAD_IDX_W-1:0] OFF_ANT_STATUS = 5'd6;
    localparam logic [LEAD_IDX_W-1:0] OFF_ANT_POWER  = 5'd7;
    localparam logic [LEAD_IDX_W-1:0] OFF_NOISE_LO   = 5'd16;
    localparam logic [LEAD_IDX_W-1:0] OFF_NOISE_HI   = 5'd17;
    localparam logic [LEAD_IDX_W-1:0] OFF_AGC_LO     = 5'd18;
    localparam logic [LEAD_IDX_W-1:0] OFF_AGC_HI     = 5'd19;
    localparam logic [LEAD_IDX_W-1:0] OFF_MAG_I      = 5'd22;
    localparam logic [LEAD_IDX_W-1:0] OFF_MAG_Q      = 5'd24;

    localparam logic [15:0] RF_MIN_LEN    = 16'd28;
    localparam logic [15:0] OFF_SAT_COUNT = 16'd5;
    localparam logic [15:0] REC_BASE      = 16'd8;
    localparam logic [3:0]  REC_LAST      = 4'd11;
    localparam logic [3:0]  REC_CNO       = 4'd2;

    // Op queue
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

endpackage

`default_nettype wire

[sv/ubxs_in_if.sv]
`default_nettype none

interface ubxs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[sv/ubxs_out_if.sv]
`default_nettype none

interface ubxs_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  done_class;
    logic [7:0]  done_id;
    logic [1:0]  frame_kind;
    logic [1:0]  jamming_state;
    logic [7:0]  antenna_status;
    logic [7:0]  antenna_power;
    logic [15:0] noise_per_ms;
    logic [15:0] agc_count;
    logic [7:0]  mag_i;
    logic [7:0]  mag_q;
    logic [7:0]  sat_count;
    logic [7:0]  max_cno;

    modport source (
        output valid, output done_class, output done_id, output frame_kind,
        output jamming_state, output antenna_status, output antenna_power,
        output noise_per_ms, output agc_count, output mag_i, output mag_q,
        output sat_count, output max_cno, input ready
    );
    modport sink (
        input valid, input done_class, input done_id, input frame_kind,
        input jamming_state, input antenna_status, input antenna_power,
        input noise_per_ms, input agc_count, input mag_i, input mag_q,
        input sat_count, input max_cno, output ready
    );
endinterface

`default_nettype wire

[sv/ubxs_front.sv]
`default_nettype none

module ubxs_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    ubxs_in_if.sink          i_in,
    input  ubxs_pkg::t_cfg   i_cfg,
    input  wire              i_q_full,
    output logic             o_push,
    output ubxs_pkg::t_qent  o_push_data
);
    import ubxs_pkg::*;

    typedef enum logic [8:0] {
        S_SYNC1   = 9'b0_0000_0001,
        S_SYNC2   = 9'b0_0000_0010,
        S_CLASS   = 9'b0_0000_0100,
        S_ID      = 9'b0_0000_1000,
        S_LEN1    = 9'b0_0001_0000,
        S_LEN2    = 9'b0_0010_0000,
        S_PAYLOAD = 9'b0_0100_0000,
        S_CKA     = 9'b0_1000_0000,
        S_CKB     = 9'b1_0000_0000
    } t_phase;

    t_phase      r_state, n_state;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_idx, n_idx;
    logic [3:0]  r_rec, n_rec;

    logic        accept;
    logic        sat_match;
    logic        rf_match;
    logic [15:0] idx_inc;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    // Frame classification from the header
    assign sat_match = (r_class == i_cfg.nav_class) && (r_id == i_cfg.sat_id);
    assign rf_match  = (r_class == i_cfg.mon_class) && (r_id == i_cfg.rf_id)
                       && (r_len >= RF_MIN_LEN);
    assign idx_inc   = r_idx + 16'd1;

    // Op payload; op code and push are chosen by the phase below
    always_comb begin
        o_push_data.op      = OP_PAY;
        o_push_data.data    = i_in.rx_byte;
        o_push_data.idx     = r_idx[LEAD_IDX_W-1:0];
        o_push_data.in_lead = (r_idx[15:LEAD_IDX_W] == '0);
        o_push_data.sat_cnt = sat_match && (r_idx == OFF_SAT_COUNT);
        o_push_data.cno     = sat_match && (r_idx >= REC_BASE) && (r_rec == REC_CNO);
        o_push_data.cls     = r_class;
        o_push_data.id      = r_id;
        if (rf_match) begin
            o_push_data.kind = KIND_RF;
        end else if (sat_match) begin
            o_push_data.kind = KIND_SAT;
        end else begin
            o_push_data.kind = KIND_OTHER;
        end

        n_state = r_state;
        n_class = r_class;
        n_id    = r_id;
        n_len   = r_len;
        n_idx   = r_idx;
        n_rec   = r_rec;
        o_push  = 1'b0;

        if (accept) begin
            case (r_state)
                S_SYNC2: begin
                    n_state = (i_in.rx_byte == i_cfg.sync_second) ? S_CLASS : S_SYNC1;
                end
                S_CLASS: begin
                    n_class = i_in.rx_byte;
                    n_state = S_ID;
                end
                S_ID: begin
                    n_id    = i_in.rx_byte;
                    n_state = S_LEN1;
                end
                S_LEN1: begin
                    n_len   = {8'd0, i_in.rx_byte};
                    n_state = S_LEN2;
                end
                S_LEN2: begin
                    n_len          = {i_in.rx_byte, r_len[7:0]};
                    n_idx          = '0;
                    n_rec          = '0;
                    o_push         = 1'b1;
                    o_push_data.op = OP_START;
                    n_state = ({i_in.rx_byte, r_len[7:0]} == 16'd0) ? S_CKA : S_PAYLOAD;
                end
                S_PAYLOAD: begin
                    o_push = 1'b1;
                    n_idx  = idx_inc;
                    // record phase tracks (index - 8) mod 12
                    if (r_idx >= REC_BASE) begin
                        n_rec = (r_rec == REC_LAST) ? 4'd0 : r_rec + 4'd1;
                    end else begin
                        n_rec = 4'd0;
                    end
                    if (idx_inc >= r_len) begin
                        n_state = S_CKA;
                    end
                end
                S_CKA: begin
                    n_state = S_CKB;
                end
                S_CKB: begin
                    o_push         = 1'b1;
                    o_push_data.op = OP_FINISH;
                    n_state        = S_SYNC1;
                end
                default: begin
                    n_state = (i_in.rx_byte == i_cfg.sync_first) ? S_SYNC2 : S_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SYNC1;
            r_class <= '0;
            r_id    <= '0;
            r_len   <= '0;
            r_idx   <= '0;
            r_rec   <= '0;
        end else begin
            r_state <= n_state;
            r_class <= n_class;
            r_id    <= n_id;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_rec   <= n_rec;
        end
    end

endmodule

`default_nettype wire

[sv/ubxs_queue.sv]
`default_nettype none

module ubxs_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  ubxs_pkg::t_qent  i_push_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output ubxs_pkg::t_qent  o_head
);
    import ubxs_pkg::*;

    localparam logic [Q_CNT_W-1:0] FULL_CNT = Q_CNT_W'(Q_DEPTH);

    t_qent              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    // Pointer and fill count update
    always_comb begin
        n_wr  = i_push ? r_wr + Q_PTR_W'(1) : r_wr;
        n_rd  = i_pop  ? r_rd + Q_PTR_W'(1) : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + Q_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[sv/ubxs_back.sv]
`default_nettype none

module ubxs_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_q_valid,
    input  ubxs_pkg::t_qent  i_q_head,
    output logic             o_pop,
    ubxs_out_if.source       o_out
);
    import ubxs_pkg::*;

    // running satellite values of the frame in flight
    logic [7:0]  r_run_sat, n_run_sat;
    logic [7:0]  r_run_cno, n_run_cno;
    // RF block-0 bytes staged from the current payload
    logic [1:0]  r_st_jam, n_st_jam;
    logic [7:0]  r_st_ant_status, n_st_ant_status;
    logic [7:0]  r_st_ant_power, n_st_ant_power;
    logic [15:0] r_st_noise, n_st_noise;
    logic [15:0] r_st_agc, n_st_agc;
    logic [7:0]  r_st_mag_i, n_st_mag_i;
    logic [7:0]  r_st_mag_q, n_st_mag_q;
    // held snapshots, shown with every result
    logic [1:0]  r_jam, n_jam;
    logic [7:0]  r_ant_status, n_ant_status;
    logic [7:0]  r_ant_power, n_ant_power;
    logic [15:0] r_noise, n_noise;
    logic [15:0] r_agc, n_agc;
    logic [7:0]  r_mag_i, n_mag_i;
    logic [7:0]  r_mag_q, n_mag_q;
    logic [7:0]  r_sat_count, n_sat_count;
    logic [7:0]  r_max_cno, n_max_cno;
    // result register
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_done_class, n_done_class;
    logic [7:0]  r_done_id, n_done_id;
    t_kind       r_kind, n_kind;

    logic        out_free;
    logic        is_finish;

    assign out_free  = !r_out_valid || o_out.ready;
    assign is_finish = (i_q_head.op == OP_FINISH);
    // only a finished frame waits on the result register
    assign o_pop     = i_q_valid && (!is_finish || out_free);

    always_comb begin
        n_run_sat       = r_run_sat;
        n_run_cno       = r_run_cno;
        n_st_jam        = r_st_jam;
        n_st_ant_status = r_st_ant_status;
        n_st_ant_power  = r_st_ant_power;
        n_st_noise      = r_st_noise;
        n_st_agc        = r_st_agc;
        n_st_mag_i      = r_st_mag_i;
        n_st_mag_q      = r_st_mag_q;
        n_jam           = r_jam;
        n_ant_status    = r_ant_status;
        n_ant_power     = r_ant_power;
        n_noise         = r_noise;
        n_agc           = r_agc;
        n_mag_i         = r_mag_i;
        n_mag_q         = r_mag_q;
        n_sat_count     = r_sat_count;
        n_max_cno       = r_max_cno;
        n_done_class    = r_done_class;
        n_done_id       = r_done_id;
        n_kind          = r_kind;
        n_out_valid     = o_out.ready ? 1'b0 : r_out_valid;

        if (o_pop) begin
            case (i_q_head.op)
                OP_START: begin
                    n_run_sat = '0;
                    n_run_cno = '0;
                end
                OP_PAY: begin
                    if (i_q_head.sat_cnt) begin
                        n_run_sat = i_q_head.data;
                    end
                    if (i_q_head.cno && (i_q_head.data > r_run_cno)) begin
                        n_run_cno = i_q_head.data;
                    end
                    // stage the block-0 bytes by payload offset
                    if (i_q_head.in_lead) begin
                        case (i_q_head.idx)
                            OFF_RF_FLAGS:   n_st_jam        = i_q_head.data[1:0];
                            OFF_ANT_STATUS: n_st_ant_status = i_q_head.data;
                            OFF_ANT_POWER:  n_st_ant_power  = i_q_head.data;
                            OFF_NOISE_LO:   n_st_noise[7:0] = i_q_head.data;
                            OFF_NOISE_HI:   n_st_noise[15:8] = i_q_head.data;
                            OFF_AGC_LO:     n_st_agc[7:0]   = i_q_head.data;
                            OFF_AGC_HI:     n_st_agc[15:8]  = i_q_head.data;
                            OFF_MAG_I:      n_st_mag_i      = i_q_head.data;
                            OFF_MAG_Q:      n_st_mag_q      = i_q_head.data;
                            default: begin
                            end
                        endcase
                    end
                end
                OP_FINISH: begin
                    n_out_valid  = 1'b1;
                    n_done_class = i_q_head.cls;
                    n_done_id    = i_q_head.id;
                    n_kind       = i_q_head.kind;
                    if (i_q_head.kind == KIND_RF) begin
                        n_jam        = r_st_jam;
                        n_ant_status = r_st_ant_status;
                        n_ant_power  = r_st_ant_power;
                        n_noise      = r_st_noise;
                        n_agc        = r_st_agc;
                        n_mag_i      = r_st_mag_i;
                        n_mag_q      = r_st_mag_q;
                    end else if (i_q_head.kind == KIND_SAT) begin
                        n_sat_count = r_run_sat;
                        n_max_cno   = r_run_cno;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // staging and result payload
    always_ff @(posedge i_clk) begin
        r_st_jam        <= n_st_jam;
        r_st_ant_status <= n_st_ant_status;
        r_st_ant_power  <= n_st_ant_power;
        r_st_noise      <= n_st_noise;
        r_st_agc        <= n_st_agc;
        r_st_mag_i      <= n_st_mag_i;
        r_st_mag_q      <= n_st_mag_q;
        r_done_class    <= n_done_class;
        r_done_id       <= n_done_id;
        r_kind          <= n_kind;
    end

    // control and held snapshots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_run_sat    <= '0;
            r_run_cno    <= '0;
            r_jam        <= '0;
            r_ant_status <= '0;
            r_ant_power  <= '0;
            r_noise      <= '0;
            r_agc        <= '0;
            r_mag_i      <= '0;
            r_mag_q      <= '0;
            r_sat_count  <= '0;
            r_max_cno    <= '0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_run_sat    <= n_run_sat;
            r_run_cno    <= n_run_cno;
            r_jam        <= n_jam;
            r_ant_status <= n_ant_status;
            r_ant_power  <= n_ant_power;
            r_noise      <= n_noise;
            r_agc        <= n_agc;
            r_mag_i      <= n_mag_i;
            r_mag_q      <= n_mag_q;
            r_sat_count  <= n_sat_count;
            r_max_cno    <= n_max_cno;
        end
    end

    // snapshots stay still while a result waits, so they drive the port directly
    assign o_out.valid          = r_out_valid;
    assign o_out.done_class     = r_done_class;
    assign o_out.done_id        = r_done_id;
    assign o_out.frame_kind     = r_kind;
    assign o_out.jamming_state  = r_jam;
    assign o_out.antenna_status = r_ant_status;
    assign o_out.antenna_power  = r_ant_power;
    assign o_out.noise_per_ms   = r_noise;
    assign o_out.agc_count      = r_agc;
    assign o_out.mag_i          = r_mag_i;
    assign o_out.mag_q          = r_mag_q;
    assign o_out.sat_count      = r_sat_count;
    assign o_out.max_cno        = r_max_cno;

endmodule

`default_nettype wire

[sv/ubx_frame_sniffer_rf_sat_stats_top.sv]
// UBX frame sniffer: takes one received serial byte per item on i_in and
// frames UBX binary messages (two sync bytes, class, id, 16-bit little-endian
// length, payload, two checksum bytes that are skipped, not checked). Each
// completed frame gives one item on o_out with its class and id, a kind code
// (0 other, 1 RF snapshot updated, 2 satellite snapshot updated) and the held
// RF block-0 and satellite snapshots, which read zero until first captured.
// A byte is taken every clock cycle while the op queue has room. A framer
// feeds a two-entry op queue ahead of the capture logic, so input stalls
// only when a result sits unread in the output register and the queue
// behind it has filled. Sync bytes and the class/id codes of the two
// decoded reports are set over the write port (indexes 0..5); the user must
// write them only while the block is idle, which the block does not enforce.
`default_nettype none

module ubx_frame_sniffer_rf_sat_stats_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    ubxs_in_if.sink                           i_in,
    ubxs_out_if.source                        o_out,
    input  wire                               i_cfg_we,
    input  wire [ubxs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [7:0]                         i_cfg_wdata
);
    import ubxs_pkg::*;

    t_cfg  r_cfg;
    logic  push;
    t_qent push_data;
    logic  q_full;
    logic  q_valid;
    t_qent q_head;
    logic  pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= SYNC_FIRST_RST;
            r_cfg.sync_second <= SYNC_SECOND_RST;
            r_cfg.nav_class   <= NAV_CLASS_RST;
            r_cfg.sat_id      <= SAT_ID_RST;
            r_cfg.mon_class   <= MON_CLASS_RST;
            r_cfg.rf_id       <= RF_ID_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_wdata;
                CFG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_wdata;
                CFG_NAV_CLASS:   r_cfg.nav_class   <= i_cfg_wdata;
                CFG_SAT_ID:      r_cfg.sat_id      <= i_cfg_wdata;
                CFG_MON_CLASS:   r_cfg.mon_class   <= i_cfg_wdata;
                CFG_RF_ID:       r_cfg.rf_id       <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    ubxs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    ubxs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_head      (q_head)
    );

    ubxs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

[sv/ubxs_chk.sv]
`default_nettype none
`include "ubx_frame_sniffer_rf_sat_stats_top_assert.svh"

module ubxs_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [7:0]  i_done_class,
    input wire [7:0]  i_done_id,
    input wire [1:0]  i_frame_kind,
    input wire [1:0]  i_jamming_state,
    input wire [7:0]  i_antenna_status,
    input wire [7:0]  i_antenna_power,
    input wire [15:0] i_noise_per_ms,
    input wire [15:0] i_agc_count,
    input wire [7:0]  i_mag_i,
    input wire [7:0]  i_mag_q,
    input wire [7:0]  i_sat_count,
    input wire [7:0]  i_max_cno
);
    import ubxs_pkg::*;

    // kind code is one of the three defined values
    `UBXS_ASSERT_IMP(a_kind_legal, i_out_valid, (i_frame_kind == KIND_OTHER) || (i_frame_kind == KIND_RF) || (i_frame_kind == KIND_SAT), "frame_kind out of range")

    // with no result waiting the op queue drains, so input is never held off
    `UBXS_ASSERT_IMP(a_ready_when_out_empty, !i_out_valid, i_in_ready, "input stalled with empty output")

    // a stalled result keeps its whole payload
    `UBXS_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_done_class) && $stable(i_done_id) && $stable(i_frame_kind) && $stable(i_jamming_state) && $stable(i_antenna_status) && $stable(i_antenna_power) && $stable(i_noise_per_ms) && $stable(i_agc_count) && $stable(i_mag_i) && $stable(i_mag_q) && $stable(i_sat_count) && $stable(i_max_cno), "stalled result changed")

    // input is held off only while a result waits in the output register
    `UBXS_ASSERT_IMP(a_in_accept_ready, i_in_valid && !i_in_ready, !i_out_valid == 1'b0, "input stalled without a waiting result")

endmodule

bind ubx_frame_sniffer_rf_sat_stats_top ubxs_chk u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_done_class     (o_out.done_class),
    .i_done_id        (o_out.done_id),
    .i_frame_kind     (o_out.frame_kind),
    .i_jamming_state  (o_out.jamming_state),
    .i_antenna_status (o_out.antenna_status),
    .i_antenna_power  (o_out.antenna_power),
    .i_noise_per_ms   (o_out.noise_per_ms),
    .i_agc_count      (o_out.agc_count),
    .i_mag_i          (o_out.mag_i),
    .i_mag_q          (o_out.mag_q),
    .i_sat_count      (o_out.sat_count),
    .i_max_cno        (o_out.max_cno)
);

`default_nettype wire
